[rtl/core/lc3b_pkg.sv]
// Package for the LC-3b instruction executor: sizes, opcodes and FSM states.
// No dependencies.
`default_nettype none
package lc3b_pkg;
  localparam int MemWords = 32768;
  localparam int MemAw    = $clog2(MemWords);

  localparam logic [3:0] OP_BR  = 4'h0;
  localparam logic [3:0] OP_ADD = 4'h1;
  localparam logic [3:0] OP_LDB = 4'h2;
  localparam logic [3:0] OP_STB = 4'h3;
  localparam logic [3:0] OP_JSR = 4'h4;
  localparam logic [3:0] OP_AND = 4'h5;
  localparam logic [3:0] OP_LDW = 4'h6;
  localparam logic [3:0] OP_STW = 4'h7;
  localparam logic [3:0] OP_XOR = 4'h9;
  localparam logic [3:0] OP_JMP = 4'hC;
  localparam logic [3:0] OP_SHF = 4'hD;
  localparam logic [3:0] OP_LEA = 4'hE;
  localparam logic [3:0] OP_TRAP = 4'hF;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_FETCH, ST_DECODE, ST_MEM, ST_STORE
  } state_t;

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    if (v[15]) return 3'b100;
    else if (v == 16'h0) return 3'b010;
    else return 3'b001;
  endfunction
endpackage
`default_nettype wire

[rtl/core/lc3b_ram.sv]
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module lc3b_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[rtl/core/lc3b_instruction_executor.sv]
// LC-3b instruction executor: word memory, register file, PC and flags.
// A load, or a step while stopped or at PC zero, is answered from ST_IDLE; other
// steps pass ST_FETCH and ST_DECODE, LDB/LDW/TRAP then ST_MEM, STB ST_MEM and ST_STORE.
// One item at a time; busy is high until the result strobe, the receiver
// cannot stall. Memory is shared by fetch and data access, which sets the rate.
// After reset a clearing pass writes zero to every memory word, busy held high.
// Uses lc3b_pkg and lc3b_ram.
`default_nettype none
module lc3b_instruction_executor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_func,
  input  wire logic [14:0] in_load_address,
  input  wire logic [15:0] in_load_word,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  output logic             out_valid,
  output logic [15:0]      out_next_pc,
  output logic             out_flag_n,
  output logic             out_flag_z,
  output logic             out_flag_p,
  output logic             out_reg_written,
  output logic [2:0]       out_reg_index,
  output logic [15:0]      out_reg_value,
  output logic             out_mem_written,
  output logic [15:0]      out_mem_address,
  output logic [15:0]      out_mem_value,
  output logic             out_halted,
  output logic             out_bad_opcode
);
  import lc3b_pkg::*;

  state_t state_r, state_nxt;
  logic [MemAw-1:0] clr_r;
  logic [15:0] pc_r, pc_nxt;
  logic [2:0] cc_r, cc_nxt;
  logic stop_r, stop_nxt;
  logic [15:0] rf_r [8];
  logic [15:0] ir_r, addr_r;
  logic [7:0] stb_hi_r, stb_lo_r;

  logic mem_we;
  logic [MemAw-1:0] ram_addr;
  logic [15:0] mem_wdata, mem_rdata;

  lc3b_ram #(.Width(16), .Depth(MemWords)) u_mem (
    .clk(clk), .we(mem_we), .addr(ram_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  // Decode of the fetched word (valid in ST_DECODE from mem_rdata, later from ir_r).
  logic [15:0] ir;
  assign ir = (state_r == ST_DECODE) ? mem_rdata : ir_r;
  logic [3:0] op;
  logic [2:0] dr;
  logic [15:0] b, op2, pc2, off6, off9x2, off11x2, shv, alu, addr_b, addr_w;
  logic [3:0] sa;
  assign op = ir[15:12];
  assign dr = ir[11:9];
  assign b = rf_r[ir[8:6]];
  assign op2 = ir[5] ? {{11{ir[4]}}, ir[4:0]} : rf_r[ir[2:0]];
  assign pc2 = pc_r + 16'd2;
  assign off6 = {{10{ir[5]}}, ir[5:0]};
  assign off9x2 = {{6{ir[8]}}, ir[8:0], 1'b0};
  assign off11x2 = {{4{ir[10]}}, ir[10:0], 1'b0};
  assign sa = ir[3:0];
  assign addr_b = b + off6;
  assign addr_w = b + {off6[14:0], 1'b0};
  always_comb begin
    if (!ir[4]) shv = b << sa;
    else if (ir[5]) shv = 16'($signed(b) >>> sa);
    else shv = b >> sa;
    case (op)
      OP_ADD:  alu = b + op2;
      OP_AND:  alu = b & op2;
      OP_XOR:  alu = b ^ op2;
      OP_SHF:  alu = shv;
      default: alu = 16'h0;
    endcase
  end

  logic [15:0] ldb_v;
  assign ldb_v = addr_r[0] ? {{8{mem_rdata[15]}}, mem_rdata[15:8]}
                           : {{8{mem_rdata[7]}}, mem_rdata[7:0]};

  // Result composed combinationally, registered into the out_ ports.
  logic res_v;
  logic rw, mw, bad;
  logic [2:0] ri;
  logic [15:0] rv, ma, mv;
  logic [MemAw-1:0] st_idx;
  assign st_idx = addr_r[MemAw:1];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (&clr_r) state_nxt = ST_IDLE;
      ST_IDLE:   if (start) begin
        if (!in_func || stop_r || pc_r == 16'h0) state_nxt = ST_IDLE;
        else state_nxt = ST_FETCH;
      end
      ST_FETCH:  state_nxt = ST_DECODE;
      ST_DECODE: begin
        case (op)
          OP_LDB, OP_LDW, OP_TRAP, OP_STB: state_nxt = ST_MEM;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_MEM:    state_nxt = (ir_r[15:12] == OP_STB) ? ST_STORE : ST_IDLE;
      ST_STORE:  state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    ram_addr = pc_r[MemAw:1];
    mem_wdata = 16'h0;
    res_v = 1'b0;
    rw = 1'b0; mw = 1'b0; bad = 1'b0;
    ri = 3'd0; rv = 16'h0; ma = 16'h0; mv = 16'h0;
    pc_nxt = pc_r; cc_nxt = cc_r; stop_nxt = stop_r;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1; ram_addr = clr_r;
      end
      ST_IDLE: begin
        if (start) begin
          if (!in_func) begin
            mem_we = 1'b1; ram_addr = in_load_address[MemAw-1:0];
            mem_wdata = in_load_word; res_v = 1'b1;
          end else if (stop_r || pc_r == 16'h0) begin
            stop_nxt = 1'b1; res_v = 1'b1;
          end
        end
      end
      ST_DECODE: begin
        pc_nxt = pc2;
        case (op)
          OP_ADD, OP_AND, OP_XOR, OP_SHF: begin
            rw = 1'b1; ri = dr; rv = alu; cc_nxt = cc_of(alu); res_v = 1'b1;
          end
          OP_BR: begin
            if (|(dr & cc_r)) pc_nxt = pc2 + off9x2;
            res_v = 1'b1;
          end
          OP_JMP: begin pc_nxt = b; res_v = 1'b1; end
          OP_JSR: begin
            pc_nxt = ir[11] ? pc2 + off11x2 : b;
            rw = 1'b1; ri = 3'd7; rv = pc2; res_v = 1'b1;
          end
          OP_LEA: begin rw = 1'b1; ri = dr; rv = pc2 + off9x2; res_v = 1'b1; end
          OP_STW: begin
            mem_we = 1'b1; ram_addr = addr_w[MemAw:1]; mem_wdata = rf_r[dr];
            mw = 1'b1; ma = {addr_w[15:1], 1'b0}; mv = rf_r[dr]; res_v = 1'b1;
          end
          OP_LDB, OP_STB: begin pc_nxt = pc_r; ram_addr = addr_b[MemAw:1]; end
          OP_LDW: begin pc_nxt = pc_r; ram_addr = addr_w[MemAw:1]; end
          OP_TRAP: begin pc_nxt = pc_r; ram_addr = {{(MemAw-8){1'b0}}, ir[7:0]}; end
          default: begin pc_nxt = pc_r; bad = 1'b1; res_v = 1'b1; end
        endcase
        if (bad) stop_nxt = 1'b1;
        else if (res_v && pc_nxt == 16'h0) stop_nxt = 1'b1;
      end
      ST_MEM: begin
        case (ir_r[15:12])
          OP_LDB: begin
            rw = 1'b1; ri = dr; rv = ldb_v; cc_nxt = cc_of(ldb_v);
            pc_nxt = pc2; res_v = 1'b1;
          end
          OP_LDW: begin
            rw = 1'b1; ri = dr; rv = mem_rdata; cc_nxt = cc_of(mem_rdata);
            pc_nxt = pc2; res_v = 1'b1;
          end
          OP_TRAP: begin
            rw = 1'b1; ri = 3'd7; rv = pc2; pc_nxt = mem_rdata; res_v = 1'b1;
          end
          default: ;
        endcase
        if (res_v && pc_nxt == 16'h0) stop_nxt = 1'b1;
      end
      ST_STORE: begin
        // Read-modify-write of the byte; the word was read in ST_MEM.
        mem_we = 1'b1; ram_addr = st_idx;
        mem_wdata = addr_r[0] ? {rf_r[dr][7:0], stb_lo_r} : {stb_hi_r, rf_r[dr][7:0]};
        mw = 1'b1; ma = addr_r; mv = {8'h0, rf_r[dr][7:0]};
        pc_nxt = pc2; res_v = 1'b1;
        if (pc2 == 16'h0) stop_nxt = 1'b1;
      end
      default: ;
    endcase
    if (cfg_we) begin
      pc_nxt = cfg_wdata; stop_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DECODE) begin
      ir_r <= mem_rdata;
      addr_r <= addr_b;
    end
    if (state_r == ST_MEM) begin
      stb_hi_r <= mem_rdata[15:8];
      stb_lo_r <= mem_rdata[7:0];
    end
    out_next_pc <= pc_nxt;
    out_flag_n <= cc_nxt[2];
    out_flag_z <= cc_nxt[1];
    out_flag_p <= cc_nxt[0];
    out_reg_written <= rw;
    out_reg_index <= ri;
    out_reg_value <= rv;
    out_mem_written <= mw;
    out_mem_address <= ma;
    out_mem_value <= mv;
    out_halted <= stop_nxt;
    out_bad_opcode <= bad;
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      pc_r <= 16'h0;
      cc_r <= 3'b010;
      stop_r <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 8; i++) rf_r[i] <= 16'h0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_r + 1'b1;
      pc_r <= pc_nxt;
      cc_r <= cc_nxt;
      stop_r <= stop_nxt;
      out_valid <= res_v;
      if (rw) rf_r[ri] <= rv;
    end
  end

  assign busy = (state_r != ST_IDLE);
endmodule
`default_nettype wire
